@@ rtl/core/sst_pkg.sv @@
// Shared types and constants for the sorted set toggle unit.
// No dependencies; the interfaces and the top level in rtl/core refer to it by scoped names.
package sst_pkg;

    localparam int CAPACITY      = 64;
    localparam int PAGE_W        = 32;
    localparam int COUNT_W       = $clog2(CAPACITY + 1);
    localparam int ADDR_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ENTRY_COUNT_W = 7;

    typedef logic [PAGE_W-1:0]        t_page;
    typedef logic [COUNT_W-1:0]       t_count;
    typedef logic [COUNT_W:0]         t_count_sum;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [ENTRY_COUNT_W-1:0] t_entry_count;

    typedef enum logic {
        CMD_TOGGLE = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    typedef struct packed {
        logic  command;
        t_page page;
    } t_in_word;

    typedef struct packed {
        logic         was_present;
        logic         inserted;
        logic         refused_full;
        t_entry_count entry_count;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUT,
        ST_DONE
    } t_state;

endpackage

@@ rtl/core/sst_in_if.sv @@
// Input channel of the sorted set toggle unit: valid, ready and one command word.
// Depends on sst_pkg for the payload type.
interface sst_in_if;
    logic              valid;
    logic              ready;
    sst_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/sst_out_if.sv @@
// Result channel of the sorted set toggle unit: valid, ready and one result word.
// Depends on sst_pkg for the payload type.
interface sst_out_if;
    logic               valid;
    logic               ready;
    sst_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/sst_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sst_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/sorted_set_toggle_unit.sv @@
// Top level of the sorted set toggle unit: sequencer, search and shift datapath.
// Depends on sst_pkg, sst_in_if, sst_out_if and sst_ram.
//
// Holds up to CAPACITY distinct page numbers in ascending order in one RAM with a
// registered read port. Each word is handled alone. A lower-bound binary search makes
// p probes, each a RAM read and then a compare in the single page comparator, with p
// at most ceil(log2(count+1)), and a closing ST_SRCH step; ST_DECIDE then decides.
// A lookup or a refused toggle then goes to ST_DONE. A removal moves every later
// entry down one place, reading then writing each entry, then lowers the count. An
// insertion moves entries up the same way and then places the page in ST_PUT. The
// slowest word is the removal of the lowest page of a full set of 64. Once the output
// register is free, the sequencer returns to ST_IDLE, where the next word is accepted.
// The input is ready only while the sequencer is idle; a finished result waits in the
// output register, and the next word may be accepted meanwhile. The set is empty
// after reset with no clearing pass.
module sorted_set_toggle_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sst_in_if.sink     i_in,
    sst_out_if.source  o_out
);

    sst_pkg::t_state r_state, n_state;

    logic            r_cmd,     n_cmd;
    sst_pkg::t_page  r_page,    n_page;
    sst_pkg::t_count r_lo,      n_lo;
    sst_pkg::t_count r_hi,      n_hi;
    sst_pkg::t_count r_idx,     n_idx;
    sst_pkg::t_count r_count,   n_count;
    logic            r_eq,      n_eq;
    logic            r_ins,     n_ins;
    logic            r_refused, n_refused;

    logic               r_out_valid, n_out_valid;
    sst_pkg::t_out_word r_out_data,  n_out_data;

    logic               wr_en;
    sst_pkg::t_addr     wr_addr;
    sst_pkg::t_page     wr_data;
    logic               rd_en;
    sst_pkg::t_addr     rd_addr;
    sst_pkg::t_page     rd_data;

    sst_pkg::t_count    mid;
    sst_pkg::t_count    idx_up;
    sst_pkg::t_count    idx_dn;
    logic               page_lt;
    logic               page_eq;
    logic               del;
    logic               in_fire;
    logic               out_free;

    sst_ram #(
        .WIDTH (sst_pkg::PAGE_W),
        .DEPTH (sst_pkg::CAPACITY)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign mid      = sst_pkg::t_count'((sst_pkg::t_count_sum'(r_lo)
                                         + sst_pkg::t_count_sum'(r_hi)) >> 1);
    assign idx_up   = r_idx + sst_pkg::t_count'(1);
    assign idx_dn   = r_idx - sst_pkg::t_count'(1);
    // shared comparator: stored entry against the searched page
    assign page_lt  = rd_data < r_page;
    assign page_eq  = rd_data == r_page;
    // a toggle that found its page removes it
    assign del      = r_eq;

    assign i_in.ready  = (r_state == sst_pkg::ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sst_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = sst_pkg::ST_SRCH;
                end
            end
            sst_pkg::ST_SRCH: begin
                n_state = (r_lo < r_hi) ? sst_pkg::ST_SRCH_CMP : sst_pkg::ST_DECIDE;
            end
            sst_pkg::ST_SRCH_CMP: begin
                n_state = sst_pkg::ST_SRCH;
            end
            sst_pkg::ST_DECIDE: begin
                if (r_cmd == sst_pkg::CMD_LOOKUP) begin
                    n_state = sst_pkg::ST_DONE;
                end else if (r_eq) begin
                    n_state = sst_pkg::ST_SHIFT_RD;
                end else if (r_count >= sst_pkg::t_count'(sst_pkg::CAPACITY)) begin
                    n_state = sst_pkg::ST_DONE;
                end else begin
                    n_state = sst_pkg::ST_SHIFT_RD;
                end
            end
            sst_pkg::ST_SHIFT_RD: begin
                if (del) begin
                    n_state = (idx_up < r_count) ? sst_pkg::ST_SHIFT_WR : sst_pkg::ST_DONE;
                end else begin
                    n_state = (r_idx > r_lo) ? sst_pkg::ST_SHIFT_WR : sst_pkg::ST_PUT;
                end
            end
            sst_pkg::ST_SHIFT_WR: begin
                n_state = sst_pkg::ST_SHIFT_RD;
            end
            sst_pkg::ST_PUT: begin
                n_state = sst_pkg::ST_DONE;
            end
            sst_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = sst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sst_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        n_cmd       = r_cmd;
        n_page      = r_page;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_idx       = r_idx;
        n_count     = r_count;
        n_eq        = r_eq;
        n_ins       = r_ins;
        n_refused   = r_refused;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;
        wr_addr     = r_idx[sst_pkg::ADDR_W-1:0];
        wr_data     = rd_data;
        rd_en       = 1'b0;
        rd_addr     = mid[sst_pkg::ADDR_W-1:0];

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            sst_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_cmd     = i_in.data.command;
                    n_page    = i_in.data.page;
                    n_lo      = '0;
                    n_hi      = r_count;
                    n_eq      = 1'b0;
                    n_ins     = 1'b0;
                    n_refused = 1'b0;
                end
            end
            sst_pkg::ST_SRCH: begin
                rd_en = (r_lo < r_hi);
                n_idx = mid;
            end
            sst_pkg::ST_SRCH_CMP: begin
                // r_idx holds the probed position; keep equality of the last upper bound
                if (page_lt) begin
                    n_lo = idx_up;
                end else begin
                    n_hi = r_idx;
                    n_eq = page_eq;
                end
            end
            sst_pkg::ST_DECIDE: begin
                // r_lo is the lower position of the page from here on
                if (r_cmd == sst_pkg::CMD_TOGGLE) begin
                    if (r_eq) begin
                        n_idx = r_lo;
                    end else if (r_count >= sst_pkg::t_count'(sst_pkg::CAPACITY)) begin
                        n_refused = 1'b1;
                    end else begin
                        n_idx = r_count;
                    end
                end
            end
            sst_pkg::ST_SHIFT_RD: begin
                if (del) begin
                    rd_addr = idx_up[sst_pkg::ADDR_W-1:0];
                    rd_en   = (idx_up < r_count);
                    if (!(idx_up < r_count)) begin
                        n_count = r_count - sst_pkg::t_count'(1);
                    end
                end else begin
                    rd_addr = idx_dn[sst_pkg::ADDR_W-1:0];
                    rd_en   = (r_idx > r_lo);
                end
            end
            sst_pkg::ST_SHIFT_WR: begin
                wr_en = 1'b1;
                n_idx = del ? idx_up : idx_dn;
            end
            sst_pkg::ST_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_lo[sst_pkg::ADDR_W-1:0];
                wr_data = r_page;
                n_count = r_count + sst_pkg::t_count'(1);
                n_ins   = 1'b1;
            end
            sst_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_data.was_present   = r_eq;
                    n_out_data.inserted      = r_ins;
                    n_out_data.refused_full  = r_refused;
                    n_out_data.entry_count   = sst_pkg::t_entry_count'(r_count);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sst_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_page     <= n_page;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_idx      <= n_idx;
        r_eq       <= n_eq;
        r_ins      <= n_ins;
        r_refused  <= n_refused;
        r_out_data <= n_out_data;
    end

endmodule

@@ verif/tb_sorted_set_toggle_unit.sv @@
// Testbench for sorted_set_toggle_unit: directed and random toggle and lookup traffic with a scoreboard.
// Depends on sst_pkg, sst_in_if, sst_out_if and the unit itself.
// A local sorted-set predictor computes each result word; the monitor checks them in order.
module tb_sorted_set_toggle_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1250;
    localparam int POOL_SIZE    = 80;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1000000;

    logic clk;
    logic rst_n;

    sst_in_if  in_ch ();
    sst_out_if out_ch ();

    sorted_set_toggle_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sst_pkg::t_in_word    pending_words[$];
    sst_pkg::t_out_word   expected_results[$];

    // predictor copy of the set
    sst_pkg::t_page       set_pages[sst_pkg::CAPACITY];
    int unsigned set_size = 0;

    int          error_count = 0;
    int          cycle_count = 0;
    logic        in_took = 1'b0;
    int          gap_left = 0;
    int          burst_left = 1;
    logic [15:0] stall_pat = 16'hFFFF;
    int          reload_left = 32;

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        fork
            forever #6 clk = ~clk;
            begin
                repeat (7) @(posedge clk);
                @(negedge clk);
                rst_n = 1'b1;
            end
        join
    end

    function automatic sst_pkg::t_out_word toggle_set_predict(sst_pkg::t_in_word w);
        sst_pkg::t_out_word res;
        int unsigned pos;
        int unsigned i;
        logic        hit;
        pos = 0;
        while (pos < set_size && set_pages[pos] < w.page)
            pos++;
        hit = (pos < set_size) && (set_pages[pos] == w.page);
        res.was_present = hit;
        res.inserted = 1'b0;
        res.refused_full = 1'b0;
        if (w.command == sst_pkg::CMD_TOGGLE) begin
            if (hit) begin
                for (i = pos; i + 1 < set_size; i++)
                    set_pages[i] = set_pages[i + 1];
                set_size--;
            end else if (set_size >= sst_pkg::CAPACITY) begin
                res.refused_full = 1'b1;
            end else begin
                for (i = set_size; i > pos; i--)
                    set_pages[i] = set_pages[i - 1];
                set_pages[pos] = w.page;
                set_size++;
                res.inserted = 1'b1;
            end
        end
        res.entry_count = sst_pkg::t_entry_count'(set_size);
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // driver: bursts of words separated by random gaps
    always @(negedge clk) begin
        logic next_valid;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            next_valid = in_ch.valid && !in_took;
            if (!next_valid) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_words.size() != 0) begin
                    in_ch.data <= pending_words.pop_front();
                    next_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            in_ch.valid <= next_valid;
        end
    end

    // receiver: rotate a stall pattern, reload it now and then
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= stall_pat[0];
            if (reload_left == 0) begin
                stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
                reload_left <= $urandom_range(16, 64);
            end else begin
                stall_pat <= {stall_pat[0], stall_pat[15:1]};
                reload_left <= reload_left - 1;
            end
        end
    end

    // monitor and scoreboard
    always @(posedge clk) begin
        sst_pkg::t_out_word want;
        in_took <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word %0h", $time, out_ch.data);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("was_present", 32'(want.was_present),
                                32'(out_ch.data.was_present));
                    check_field("inserted", 32'(want.inserted), 32'(out_ch.data.inserted));
                    check_field("refused_full", 32'(want.refused_full),
                                32'(out_ch.data.refused_full));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(out_ch.data.entry_count));
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_results.insert(expected_results.size(),
                                        toggle_set_predict(in_ch.data));
        end
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_word(sst_pkg::t_cmd cmd, sst_pkg::t_page page);
        sst_pkg::t_in_word w;
        w.command = cmd;
        w.page = page;
        pending_words.insert(pending_words.size(), w);
    endtask

    // hold until every queued word has been sent and answered
    task automatic wait_all_answered();
        while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        sst_pkg::t_page pool[POOL_SIZE];
        sst_pkg::t_page recent[$];
        sst_pkg::t_page page;
        sst_pkg::t_cmd  cmd;
        int    queued;
        int    n;
        int    idx;
        int    kind;

        // directed: empty set, both ends of the page range, removal at front and back
        queue_word(sst_pkg::CMD_LOOKUP, 32'h0000_0000);
        queue_word(sst_pkg::CMD_TOGGLE, 32'hFFFF_FFFF);
        queue_word(sst_pkg::CMD_TOGGLE, 32'h0000_0000);
        queue_word(sst_pkg::CMD_TOGGLE, 32'h8000_0000);
        queue_word(sst_pkg::CMD_TOGGLE, 32'h7FFF_FFFF);
        queue_word(sst_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
        queue_word(sst_pkg::CMD_LOOKUP, 32'h0000_0001);
        queue_word(sst_pkg::CMD_LOOKUP, 32'h8000_0000);
        queue_word(sst_pkg::CMD_TOGGLE, 32'h0000_0000);
        queue_word(sst_pkg::CMD_TOGGLE, 32'hFFFF_FFFF);
        queue_word(sst_pkg::CMD_TOGGLE, 32'h8000_0000);
        queue_word(sst_pkg::CMD_LOOKUP, 32'h8000_0000);
        queue_word(sst_pkg::CMD_TOGGLE, 32'h7FFF_FFFF);
        queue_word(sst_pkg::CMD_LOOKUP, 32'h7FFF_FFFF);
        queue_word(sst_pkg::CMD_TOGGLE, 32'h7FFF_FFFF);
        queue_word(sst_pkg::CMD_TOGGLE, 32'h7FFF_FFFE);
        queue_word(sst_pkg::CMD_TOGGLE, 32'h5555_5555);
        queue_word(sst_pkg::CMD_TOGGLE, 32'hAAAA_AAAA);
        queue_word(sst_pkg::CMD_LOOKUP, 32'h7FFF_FFFE);
        queue_word(sst_pkg::CMD_TOGGLE, 32'h5555_5555);
        wait_all_answered();

        // pool: edge values, a cluster around the sign bit, the rest scattered
        pool[0] = 32'h0000_0000;
        pool[1] = 32'h0000_0001;
        pool[2] = 32'hFFFF_FFFF;
        pool[3] = 32'hFFFF_FFFE;
        pool[4] = 32'h7FFF_FFFF;
        pool[5] = 32'h8000_0000;
        pool[6] = 32'h8000_0001;
        pool[7] = 32'h5555_5555;
        for (int i = 8; i < POOL_SIZE; i++)
            pool[i] = (i % 2 == 0) ? $urandom : 32'h7FFF_FFF0 + $urandom_range(0, 40);

        queued = 0;
        while (queued < RANDOM_WORDS) begin
            kind = (queued == 0) ? 0 : $urandom_range(0, 2);
            case (kind)
                0: begin
                    // fill past capacity with fresh pages so the full case is hit
                    n = $urandom_range(60, 80);
                    for (int i = 0; i < n; i++) begin
                        page = $urandom;
                        cmd = ($urandom_range(0, 9) == 0) ? sst_pkg::CMD_LOOKUP
                                                          : sst_pkg::CMD_TOGGLE;
                        queue_word(cmd, page);
                        if (recent.size() < 200)
                            recent.insert(recent.size(), page);
                    end
                end
                1: begin
                    // drain: revisit earlier pages in random order
                    n = recent.size();
                    for (int i = 0; i < n; i++) begin
                        idx = $urandom_range(0, recent.size() - 1);
                        page = recent[idx];
                        recent.delete(idx);
                        cmd = ($urandom_range(0, 7) == 0) ? sst_pkg::CMD_LOOKUP
                                                          : sst_pkg::CMD_TOGGLE;
                        queue_word(cmd, page);
                    end
                end
                default: begin
                    // churn on a small pool so hits and misses mix
                    n = 100;
                    for (int i = 0; i < n; i++) begin
                        page = ($urandom_range(0, 15) == 0) ? $urandom
                                                           : pool[$urandom_range(0, POOL_SIZE - 1)];
                        cmd = ($urandom_range(0, 3) == 0) ? sst_pkg::CMD_LOOKUP
                                                          : sst_pkg::CMD_TOGGLE;
                        queue_word(cmd, page);
                    end
                end
            endcase
            queued += n;
            if ($urandom_range(0, 3) == 0)
                wait_all_answered();
        end

        wait_all_answered();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
